// File: hdl/cdf97_lifting_wavelet_1d_defines.svh
// assertion helpers for the wavelet block
`ifndef CDF97_LIFTING_WAVELET_1D_DEFINES_SVH
`define CDF97_LIFTING_WAVELET_1D_DEFINES_SVH

// a condition implies a consequence in the same cycle
`define CDF_ASSERT_IMP(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed");

// a condition implies a consequence in the next cycle
`define CDF_ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hdl/cdf97_pkg.sv
package cdf97_pkg;

    localparam int unsigned SW = 32;
    localparam int unsigned WW = 48;

    localparam logic signed [17:0] C_P1 = -18'sd103949;
    localparam logic signed [17:0] C_U1 = -18'sd3472;
    localparam logic signed [17:0] C_P2 = 18'sd57862;
    localparam logic signed [17:0] C_U2 = 18'sd29066;
    localparam logic signed [17:0] C_K  = 18'sd75340;
    localparam logic signed [17:0] C_RK = 18'sd57007;

    localparam logic CFG_INVERSE = 1'b0;
    localparam logic CFG_LENGTH  = 1'b1;

    // block descriptor handed from the front to the back
    typedef struct packed {
        logic       inverse;
        logic [6:0] len;
    } cdf_job_t;

    // saturate a 50 bit value to signed 48 bits
    function automatic logic signed [WW-1:0] sat48(input logic signed [WW+1:0] v);
        logic signed [WW+1:0] hi;
        logic signed [WW+1:0] lo;
        hi = {{2{1'b0}}, 1'b0, {(WW-1){1'b1}}};
        lo = -hi - 50'sd1;
        if (v > hi)
            sat48 = hi[WW-1:0];
        else if (v < lo)
            sat48 = lo[WW-1:0];
        else
            sat48 = v[WW-1:0];
    endfunction

endpackage

// File: hdl/cdf97_front.sv
module cdf97_front
    import cdf97_pkg::*;
#(
    parameter int unsigned MAX_LENGTH = 64,
    parameter int unsigned AW = 6
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic signed [SW-1:0] sample_value,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic                 cfg_index_hi,
    input  logic [6:0]           cfg_data,
    input  logic                 back_busy,
    output logic                 wr_en,
    output logic [AW-1:0]        wr_addr,
    output logic signed [WW-1:0] wr_data,
    output logic                 job_valid,
    output cdf_job_t             job
);

    localparam logic [6:0] CAP = 7'(MAX_LENGTH) & 7'h7e;

    logic       inverse_reg;
    logic [6:0] length_reg;
    logic [6:0] fill_reg;
    logic [6:0] fill_next;
    logic [6:0] eff;
    logic       accept;
    logic       done;

    always_comb
    begin
        eff = length_reg & 7'h7e;
        if (eff < 7'd2)
            eff = 7'd2;
        if (eff > CAP)
            eff = CAP;
    end

    // the store is owned by the back part until the block is out
    assign full      = back_busy;
    assign cfg_ready = 1'b1;
    assign accept    = push && !full;
    assign done      = accept && (fill_reg + 7'd1 >= eff);
    assign wr_en     = accept;
    assign wr_addr   = fill_reg[AW-1:0];
    assign wr_data   = {{(WW-SW-8){sample_value[SW-1]}}, sample_value, 8'd0};
    assign job_valid = done;
    assign job.inverse = inverse_reg;
    assign job.len     = eff;

    always_comb
    begin
        fill_next = fill_reg;
        if (accept)
            fill_next = done ? 7'd0 : fill_reg + 7'd1;
        if (cfg_valid && !cfg_index_hi)
            fill_next = 7'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inverse_reg <= 1'b0;
            length_reg  <= 7'd64;
            fill_reg    <= 7'd0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (cfg_valid && !cfg_index_hi)
            begin
                case (cfg_index)
                    CFG_INVERSE: inverse_reg <= cfg_data[0];
                    CFG_LENGTH:  length_reg  <= cfg_data;
                    default:     length_reg  <= length_reg;
                endcase
            end
        end
    end

endmodule

// File: hdl/cdf97_back.sv
module cdf97_back
    import cdf97_pkg::*;
#(
    parameter int unsigned MAX_LENGTH = 64,
    parameter int unsigned AW = 6
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  logic signed [WW-1:0] wr_data,
    input  logic                 job_valid,
    input  cdf_job_t             job,
    output logic                 busy,
    output logic                 empty,
    input  logic                 pop,
    output logic signed [SW-1:0] coeff_value,
    output logic                 last_of_block
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_LOAD  = 7'b0000010,
        S_RD    = 7'b0000100,
        S_MUL   = 7'b0001000,
        S_ACC   = 7'b0010000,
        S_STORE = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    // input store and a work store for the in-place lifting
    logic signed [WW-1:0] mem [MAX_LENGTH];
    logic signed [WW-1:0] work [MAX_LENGTH];

    state_t               state_reg;
    cdf_job_t             job_reg;
    logic [2:0]           pass_reg;
    logic [6:0]           idx_reg;
    logic signed [WW-1:0] self_reg;
    logic signed [WW:0]   sum_reg;
    logic signed [WW+18:0] prod_reg;
    logic                 out_v_reg;
    logic signed [SW-1:0] out_d_reg;
    logic                 out_l_reg;
    logic signed [WW-1:0] mem_q_reg;

    logic [2:0]           step;
    logic signed [17:0]   coef;
    logic                 is_scale;
    logic [6:0]           start;
    logic [6:0]           half;
    logic [6:0]           lm;
    logic [6:0]           rp;
    logic [6:0]           ra;
    logic [2:0]           pnext;
    logic [2:0]           nstep;
    logic [6:0]           nstart;
    logic signed [WW+1:0] acc;
    logic signed [WW+18:0] rnd;
    logic signed [WW+1:0] rounded;
    logic signed [WW:0]   ow;
    logic signed [WW-8:0] osh;
    logic signed [SW-1:0] osat;
    logic                 out_take;
    logic                 out_load;

    assign half = {1'b0, job_reg.len[6:1]};
    assign busy = (state_reg != S_IDLE);
    assign empty = !out_v_reg;
    assign coeff_value = out_d_reg;
    assign last_of_block = out_l_reg;
    assign out_take = out_v_reg && pop;
    assign out_load = (state_reg == S_OUT) && (!out_v_reg || out_take);

    // pass order: forward p1 u1 p2 u2 scale, inverse scale u2 p2 u1 p1
    always_comb
    begin
        step = job_reg.inverse ? 3'd4 - pass_reg : pass_reg;
        if (job_reg.inverse && pass_reg == 3'd0)
            step = 3'd4;
        else if (job_reg.inverse)
            step = 3'd4 - pass_reg;
        is_scale = (step == 3'd4);
        case (step)
            3'd0:    coef = C_P1;
            3'd1:    coef = C_U1;
            3'd2:    coef = C_P2;
            3'd3:    coef = C_U2;
            default: coef = (idx_reg[0] ^ job_reg.inverse) ? C_RK : C_K;
        endcase
        if (job_reg.inverse && !is_scale)
            coef = -coef;
        start = {6'd0, ~step[0]} ;
        if (is_scale)
            start = 7'd0;
        // first index of the following pass
        pnext  = pass_reg + 3'd1;
        nstep  = job_reg.inverse ? 3'd4 - pnext : pnext;
        nstart = (nstep == 3'd4) ? 7'd0 : {6'd0, ~nstep[0]};
        lm = (idx_reg == 7'd0) ? 7'd1 : idx_reg - 7'd1;
        rp = (idx_reg + 7'd1 >= job_reg.len) ? idx_reg - 7'd1 : idx_reg + 7'd1;
        ra = is_scale ? idx_reg : lm;
    end

    // round half up by adding half an lsb before the arithmetic shift
    always_comb
    begin
        rnd     = prod_reg + 67'sd32768;
        rounded = 50'(rnd >>> 16);
        acc     = is_scale ? rounded : {{2{self_reg[WW-1]}}, self_reg} + rounded;
        ow      = {mem_q_reg[WW-1], mem_q_reg} + 49'sd128;
        osh     = ow[WW:8];
        if (osh > 41'sd2147483647)
            osat = 32'sh7fffffff;
        else if (osh < -41'sd2147483648)
            osat = 32'sh80000000;
        else
            osat = osh[SW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (state_reg == S_LOAD)
        begin
            if (job_reg.inverse)
                work[AW'(idx_reg < half ? {idx_reg, 1'b0} : {idx_reg - half, 1'b1})]
                    <= mem[idx_reg[AW-1:0]];
            else
                work[idx_reg[AW-1:0]] <= mem[idx_reg[AW-1:0]];
        end
        // neighbours in this cycle, the entry itself in the next
        if (state_reg == S_RD)
            sum_reg <= {work[ra[AW-1:0]][WW-1], work[ra[AW-1:0]]}
                + (is_scale ? 49'sd0 : {work[rp[AW-1:0]][WW-1], work[rp[AW-1:0]]});
        if (state_reg == S_MUL)
        begin
            self_reg <= work[idx_reg[AW-1:0]];
            prod_reg <= sum_reg * coef;
        end
        if (state_reg == S_ACC)
            work[idx_reg[AW-1:0]] <= sat48(acc);
        if (state_reg == S_STORE)
        begin
            if (job_reg.inverse)
                mem_q_reg <= work[idx_reg[AW-1:0]];
            else
                mem_q_reg <= work[AW'(idx_reg < half ? {idx_reg[5:0], 1'b0}
                    : {idx_reg - half, 1'b1})];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pass_reg  <= 3'd0;
            idx_reg   <= 7'd0;
            out_v_reg <= 1'b0;
            out_d_reg <= '0;
            out_l_reg <= 1'b0;
            job_reg   <= '0;
        end
        else
        begin
            if (out_load)
                out_v_reg <= 1'b1;
            else if (out_take)
                out_v_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        job_reg   <= job;
                        idx_reg   <= 7'd0;
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    if (idx_reg + 7'd1 >= job_reg.len)
                    begin
                        pass_reg  <= 3'd0;
                        idx_reg   <= job_reg.inverse ? 7'd0 : 7'd1;
                        state_reg <= S_RD;
                    end
                    else
                        idx_reg <= idx_reg + 7'd1;
                end
                S_RD:  state_reg <= S_MUL;
                S_MUL: state_reg <= S_ACC;
                S_ACC:
                begin
                    if (idx_reg + (is_scale ? 7'd1 : 7'd2) < job_reg.len)
                    begin
                        idx_reg   <= idx_reg + (is_scale ? 7'd1 : 7'd2);
                        state_reg <= S_RD;
                    end
                    else if (pass_reg == 3'd4)
                    begin
                        idx_reg   <= 7'd0;
                        state_reg <= S_STORE;
                    end
                    else
                    begin
                        pass_reg  <= pass_reg + 3'd1;
                        idx_reg   <= nstart;
                        state_reg <= S_RD;
                    end
                end
                S_STORE: state_reg <= S_OUT;
                S_OUT:
                begin
                    if (out_load)
                    begin
                        out_d_reg <= osat;
                        out_l_reg <= (idx_reg + 7'd1 >= job_reg.len);
                        if (idx_reg + 7'd1 >= job_reg.len)
                            state_reg <= S_IDLE;
                        else
                        begin
                            idx_reg   <= idx_reg + 7'd1;
                            state_reg <= S_STORE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// File: hdl/cdf97_lifting_wavelet_1d.sv
// operation: L input samples, then the load into the work store, then the lifting and
// scaling passes in a read, multiply, write loop with one shared multiplier, then a store
// and an output step per result, where output waits for the result register to be free;
// input is held off from load until the last result is registered, so one block at a time
// reset: asynchronous active low; length 64, forward mode, fill count zero, queue empty
`include "cdf97_lifting_wavelet_1d_defines.svh"
module cdf97_lifting_wavelet_1d
    import cdf97_pkg::*;
#(
    parameter int unsigned MAX_LENGTH = 64
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic signed [31:0]   sample_value,
    output logic                 empty,
    input  logic                 pop,
    output logic signed [31:0]   coeff_value,
    output logic                 last_of_block,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [6:0]           cfg_data
);

    localparam int unsigned AW = $clog2(MAX_LENGTH);

    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic signed [WW-1:0] wr_data;
    logic                 job_valid;
    cdf_job_t             job;
    logic                 back_busy;

    cdf97_front #(.MAX_LENGTH(MAX_LENGTH), .AW(AW)) u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .sample_value(sample_value), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index[0]), .cfg_index_hi(cfg_index[1]), .cfg_data(cfg_data),
        .back_busy(back_busy), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .job_valid(job_valid), .job(job)
    );

    cdf97_back #(.MAX_LENGTH(MAX_LENGTH), .AW(AW)) u_back (
        .clk(clk), .rst_n(rst_n), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .job_valid(job_valid), .job(job), .busy(back_busy), .empty(empty), .pop(pop),
        .coeff_value(coeff_value), .last_of_block(last_of_block)
    );

    `CDF_ASSERT_NEXT(a_job_busy, job_valid, full)
    `CDF_ASSERT_IMP(a_no_push_busy, back_busy, !wr_en)
    `CDF_ASSERT_NEXT(a_hold_out, !empty && !pop, !empty)

endmodule

// File: tb/sv/cdf97_lifting_wavelet_1d_tb.sv
`timescale 1ns / 100ps
module cdf97_lifting_wavelet_1d_tb;
    import cdf97_pkg::*;

    localparam int unsigned MAX_LEN = 64;
    localparam int unsigned QUIET_CYCLES = 800;
    localparam int unsigned ITEM_TARGET = 370;

    localparam logic [1:0] REG_INVERSE = {1'b0, CFG_INVERSE};
    localparam logic [1:0] REG_LENGTH  = {1'b0, CFG_LENGTH};
    localparam logic [1:0] REG_SPARE_A = 2'd2;
    localparam logic [1:0] REG_SPARE_B = 2'd3;

    localparam longint Q16_P1 = -103949;
    localparam longint Q16_U1 = -3472;
    localparam longint Q16_P2 = 57862;
    localparam longint Q16_U2 = 29066;
    localparam longint Q16_K  = 75340;
    localparam longint Q16_RK = 57007;
    localparam longint S48_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint S48_LO = -S48_HI - 1;

    typedef enum logic [1:0] {OP_SAMPLE, OP_CONFIG, OP_QUIET} op_kind_t;

    typedef struct {
        op_kind_t           kind;
        logic [1:0]         idx;
        logic [6:0]         data;
        logic signed [31:0] value;
        int unsigned        gap;
    } op_t;

    typedef struct {
        logic signed [31:0] coeff;
        logic               last;
    } coeff_t;

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    logic signed [31:0] sample_value;
    logic               empty;
    logic               pop;
    logic signed [31:0] coeff_value;
    logic               last_of_block;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [6:0]         cfg_data;

    cdf97_lifting_wavelet_1d u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .sample_value  (sample_value),
        .empty         (empty),
        .pop           (pop),
        .coeff_value   (coeff_value),
        .last_of_block (last_of_block),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    op_t    plan_q[$];
    coeff_t coeff_q[$];
    int     fail_count;
    int     sample_total;
    logic   calm;
    logic   stim_done;

    // predictor state
    logic        mdl_inverse;
    logic [6:0]  mdl_length;
    longint      mdl_store[MAX_LEN];
    int unsigned mdl_fill;
    longint      work[MAX_LEN];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report(input string what, input logic signed [31:0] got,
                          input logic signed [31:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    function automatic longint sat_w(input longint v);
        if (v > S48_HI)
            return S48_HI;
        if (v < S48_LO)
            return S48_LO;
        return v;
    endfunction

    // product shifted by 16, round half up, without overflowing 64 bits
    function automatic longint mul_round(input longint v, input longint c);
        longint hi;
        longint lo;
        hi = v >>> 16;
        lo = v - hi * 65536;
        return hi * c + ((lo * c + 32768) >>> 16);
    endfunction

    function automatic int unsigned reflect(input int i, input int unsigned n);
        if (i < 0)
            return -i;
        if (i >= int'(n))
            return 2 * n - i - 2;
        return i;
    endfunction

    task automatic lift_pass(input int unsigned n, input int unsigned first, input longint c);
        longint s;
        for (int unsigned i = first; i < n; i += 2)
        begin
            s = work[reflect(int'(i) - 1, n)] + work[reflect(int'(i) + 1, n)];
            work[i] = sat_w(work[i] + mul_round(s, c));
        end
    endtask

    task automatic scale_pass(input int unsigned n, input longint ce, input longint co);
        for (int unsigned i = 0; i + 1 < n; i += 2)
        begin
            work[i]     = sat_w(mul_round(work[i], ce));
            work[i + 1] = sat_w(mul_round(work[i + 1], co));
        end
    endtask

    function automatic int unsigned active_length(input logic [6:0] l);
        int unsigned n;
        n = l & 7'h7E;
        if (n < 2)
            n = 2;
        if (n > MAX_LEN)
            n = MAX_LEN;
        return n;
    endfunction

    task automatic transform_sample(input logic signed [31:0] s);
        int unsigned n;
        int unsigned h;
        longint      r;
        coeff_t      c;
        n = active_length(mdl_length);
        if (mdl_fill >= n)
            mdl_fill = 0;
        mdl_store[mdl_fill] = longint'(s) * 256;
        mdl_fill++;
        if (mdl_fill < n)
            return;
        mdl_fill = 0;
        h = n / 2;
        if (!mdl_inverse)
        begin
            for (int unsigned i = 0; i < n; i++)
                work[i] = mdl_store[i];
            lift_pass(n, 1, Q16_P1);
            lift_pass(n, 0, Q16_U1);
            lift_pass(n, 1, Q16_P2);
            lift_pass(n, 0, Q16_U2);
            scale_pass(n, Q16_K, Q16_RK);
            for (int unsigned i = 0; i < h; i++)
            begin
                mdl_store[i]     = work[2 * i];
                mdl_store[i + h] = work[2 * i + 1];
            end
        end
        else
        begin
            for (int unsigned i = 0; i < h; i++)
            begin
                work[2 * i]     = mdl_store[i];
                work[2 * i + 1] = mdl_store[i + h];
            end
            scale_pass(n, Q16_RK, Q16_K);
            lift_pass(n, 0, -Q16_U2);
            lift_pass(n, 1, -Q16_P2);
            lift_pass(n, 0, -Q16_U1);
            lift_pass(n, 1, -Q16_P1);
            for (int unsigned i = 0; i < n; i++)
                mdl_store[i] = work[i];
        end
        for (int unsigned i = 0; i < n; i++)
        begin
            r = (mdl_store[i] + 128) >>> 8;
            if (r > 64'sd2147483647)
                r = 64'sd2147483647;
            if (r < -64'sd2147483648)
                r = -64'sd2147483648;
            c.coeff = r[31:0];
            c.last  = (i == n - 1);
            coeff_q.push_back(c);
        end
    endtask

    // plan building
    task automatic add_cfg(input logic [1:0] idx, input logic [6:0] data);
        op_t o;
        o = '{kind: OP_CONFIG, idx: idx, data: data, value: '0, gap: 0};
        plan_q.push_back(o);
    endtask

    task automatic add_quiet();
        op_t o;
        o = '{kind: OP_QUIET, idx: '0, data: '0, value: '0, gap: 0};
        plan_q.push_back(o);
    endtask

    task automatic add_sample(input logic signed [31:0] v);
        op_t o;
        o = '{kind: OP_SAMPLE, idx: '0, data: '0, value: v,
              gap: calm ? 0 : $urandom_range(0, 8)};
        plan_q.push_back(o);
        sample_total++;
    endtask

    function automatic logic signed [31:0] draw_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2, 3:    return $urandom;
            4:       return $signed($urandom_range(0, 65535)) - 32768;
            default: return $signed($urandom_range(0, 2097151)) - 1048576;
        endcase
    endfunction

    // driver
    int unsigned drv_wait;
    int unsigned drv_quiet;
    op_t         drv_op;
    logic        nxt_push;
    logic        nxt_cfg;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push         <= 1'b0;
            sample_value <= '0;
            cfg_valid    <= 1'b0;
            cfg_index    <= '0;
            cfg_data     <= '0;
            drv_wait     <= 0;
            drv_quiet    <= 0;
            stim_done    <= 1'b0;
        end
        else if ((push && full) || (cfg_valid && !cfg_ready))
        begin
            // transaction still pending, hold everything
        end
        else
        begin
            nxt_push = 1'b0;
            nxt_cfg  = 1'b0;
            if (drv_wait != 0)
                drv_wait <= drv_wait - 1;
            else if (plan_q.size() == 0)
                stim_done <= 1'b1;
            else
            begin
                drv_op = plan_q[0];
                if (drv_op.kind == OP_SAMPLE)
                begin
                    nxt_push = 1'b1;
                    sample_value <= drv_op.value;
                    drv_wait <= drv_op.gap;
                    void'(plan_q.pop_front());
                end
                else if (coeff_q.size() != 0)
                    drv_quiet <= 0;
                else if (drv_quiet < QUIET_CYCLES)
                    drv_quiet <= drv_quiet + 1;
                else
                begin
                    drv_quiet <= 0;
                    if (drv_op.kind == OP_CONFIG)
                    begin
                        nxt_cfg = 1'b1;
                        cfg_index <= drv_op.idx;
                        cfg_data  <= drv_op.data;
                    end
                    void'(plan_q.pop_front());
                end
            end
            push      <= nxt_push;
            cfg_valid <= nxt_cfg;
        end
    end

    // monitor and prediction
    int unsigned pop_wait;
    int unsigned pop_draw;
    logic        pop_calm;
    coeff_t      want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop         <= 1'b0;
            pop_wait    <= 0;
            pop_calm    <= 1'b0;
            mdl_inverse = 1'b0;
            mdl_length  = 7'd64;
            mdl_fill    = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_INVERSE)
                begin
                    mdl_inverse = cfg_data[0];
                    mdl_fill    = 0;
                end
                else if (cfg_index == REG_LENGTH)
                begin
                    mdl_length = cfg_data;
                    mdl_fill   = 0;
                end
            end
            if (push && !full)
                transform_sample(sample_value);
            if (pop && !empty)
            begin
                if (coeff_q.size() == 0)
                    report("unexpected coefficient", coeff_value, 0);
                else
                begin
                    want = coeff_q.pop_front();
                    if (coeff_value !== want.coeff)
                        report("coeff_value", coeff_value, want.coeff);
                    if (last_of_block !== want.last)
                        report("last_of_block", last_of_block, want.last);
                end
                if ($urandom_range(0, 99) == 0)
                    pop_calm <= ~pop_calm;
                pop_draw = pop_calm ? 0 : $urandom_range(0, 8);
                pop_wait <= pop_draw;
                pop      <= (pop_draw == 0);
            end
            else if (pop_wait != 0)
            begin
                pop_wait <= pop_wait - 1;
                pop      <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    initial
    begin
        int unsigned n;
        int unsigned blocks;
        logic [6:0]  l;
        fail_count   = 0;
        sample_total = 0;
        calm         = 1'b0;
        rst_n        = 1'b0;

        // directed: unknown indexes, tiny and odd lengths, extremes, abandoned block
        add_cfg(REG_SPARE_A, 7'h7F);
        add_cfg(REG_SPARE_B, 7'h00);
        add_cfg(REG_LENGTH, 7'd0);
        add_sample(32'sh7FFF_FFFF);
        add_sample(32'sh8000_0000);
        add_cfg(REG_LENGTH, 7'd1);
        add_sample(32'sh8000_0000);
        add_sample(32'sh7FFF_FFFF);
        add_cfg(REG_LENGTH, 7'd5);
        add_sample(32'sh7FFF_FFFF);
        add_sample(32'sh8000_0000);
        add_sample(32'sd0);
        add_sample(-32'sd1);
        add_cfg(REG_INVERSE, 7'd1);
        add_sample(32'sh7FFF_FFFF);
        add_sample(32'sh8000_0000);
        add_sample(32'sh8000_0000);
        add_sample(32'sh7FFF_FFFF);
        add_cfg(REG_LENGTH, 7'd8);
        add_sample(32'sd256);
        add_sample(-32'sd256);
        add_sample(32'sd1);
        add_cfg(REG_INVERSE, 7'd0);
        add_sample(32'sd1);
        add_sample(32'sd2);
        add_quiet();

        while (sample_total < ITEM_TARGET)
        begin
            calm = ($urandom_range(0, 3) == 0);
            add_cfg(REG_INVERSE, 7'($urandom_range(0, 1) | ($urandom_range(0, 63) << 1)));
            case ($urandom_range(0, 9))
                0:       l = 7'd127;
                1:       l = 7'($urandom_range(64, 126));
                2:       l = 7'($urandom_range(0, 1));
                default: l = 7'($urandom_range(2, 17));
            endcase
            add_cfg(REG_LENGTH, l);
            n = active_length(l);
            blocks = (n > 16) ? 1 : $urandom_range(1, 4);
            for (int unsigned b = 0; b < blocks; b++)
            begin
                for (int unsigned i = 0; i < n; i++)
                    add_sample(draw_value());
                if ($urandom_range(0, 4) == 0)
                    add_quiet();
            end
            // leave a partial block behind now and then
            if ($urandom_range(0, 5) == 0)
                for (int unsigned i = 0; i + 1 < n; i++)
                    add_sample(draw_value());
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        wait (stim_done);
        wait (coeff_q.size() == 0);
        repeat (QUIET_CYCLES) @(posedge clk);
        if (fail_count == 0 && coeff_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
